// ----- rtl/jsu_pkg.sv -----
// ----------------------------------------------------------------------------
// JSON string unescaper package
// Word types, scan phases, byte constants and UTF-8 helpers shared by the
// front decoder, the burst queue and the output serializer.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // Input word: one raw byte of a string body, or end of data.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_data;
  } in_t;

  // Output word: one unescaped byte, or the final status word.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       last;
    logic [1:0] status;
  } out_t;

  localparam logic [1:0] StatusOk         = 2'd0;
  localparam logic [1:0] StatusInvalid    = 2'd1;
  localparam logic [1:0] StatusIncomplete = 2'd2;

  typedef enum logic [2:0] {
    PhPlain  = 3'd0,
    PhEsc    = 3'd1,
    PhHex    = 3'd2,
    PhHigh   = 3'd3,
    PhHighBs = 3'd4,
    PhLowHex = 3'd5
  } phase_e;

  // What one accepted byte produces.
  typedef enum logic [2:0] {
    EmNone,
    EmPlain,
    EmEsc,
    EmBmp,
    EmPair,
    EmTerm
  } emit_e;

  // Up to four data bytes, or one terminating status word.
  typedef struct packed {
    logic            term;
    logic [1:0]      status;
    logic [2:0]      count;
    logic [3:0][7:0] bytes;
  } burst_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChLowB = 8'h62;
  localparam logic [7:0] ChLowF = 8'h66;
  localparam logic [7:0] ChLowN = 8'h6E;
  localparam logic [7:0] ChLowR = 8'h72;
  localparam logic [7:0] ChLowT = 8'h74;
  localparam logic [7:0] ChLowU = 8'h75;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] CtlBs = 8'h08;
  localparam logic [7:0] CtlFf = 8'h0C;
  localparam logic [7:0] CtlLf = 8'h0A;
  localparam logic [7:0] CtlCr = 8'h0D;
  localparam logic [7:0] CtlTab = 8'h09;

  localparam logic [15:0] HighFirst = 16'hD800;
  localparam logic [15:0] HighLast = 16'hDBFF;
  localparam logic [15:0] LowFirst = 16'hDC00;
  localparam logic [15:0] LowLast = 16'hDFFF;
  localparam logic [20:0] SuppBase = 21'h10000;
  localparam logic [20:0] Lim1 = 21'h80;
  localparam logic [20:0] Lim2 = 21'h800;
  localparam logic [7:0] Lead2 = 8'hC0;
  localparam logic [7:0] Lead3 = 8'hE0;
  localparam logic [7:0] Lead4 = 8'hF0;
  localparam logic [7:0] ContMark = 8'h80;
  localparam logic [7:0] ContMask = 8'h3F;

  // Returns {valid, value} for one ASCII hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  function automatic burst_t utf8_encode(input logic [20:0] cp);
    burst_t r;
    r = '0;
    if (cp < Lim1) begin
      r.count    = 3'd1;
      r.bytes[0] = cp[7:0];
    end else if (cp < Lim2) begin
      r.count    = 3'd2;
      r.bytes[0] = Lead2 | {3'b000, cp[10:6]};
      r.bytes[1] = ContMark | ({2'b00, cp[5:0]} & ContMask);
    end else if (cp < SuppBase) begin
      r.count    = 3'd3;
      r.bytes[0] = Lead3 | {4'h0, cp[15:12]};
      r.bytes[1] = ContMark | ({2'b00, cp[11:6]} & ContMask);
      r.bytes[2] = ContMark | ({2'b00, cp[5:0]} & ContMask);
    end else begin
      r.count    = 3'd4;
      r.bytes[0] = Lead4 | {5'h00, cp[20:18]};
      r.bytes[1] = ContMark | ({2'b00, cp[17:12]} & ContMask);
      r.bytes[2] = ContMark | ({2'b00, cp[11:6]} & ContMask);
      r.bytes[3] = ContMark | ({2'b00, cp[5:0]} & ContMask);
    end
    return r;
  endfunction

endpackage

// ----- rtl/json_string_unescape_utf8.sv -----
// ----------------------------------------------------------------------------
// JSON string unescaper, top level
// Unescapes the body of one JSON string into UTF-8 bytes with a final status.
// ----------------------------------------------------------------------------
// The block accepts one raw string byte per cycle whenever its burst queue
// has room, and each byte is decoded in the cycle it is accepted. A byte
// yields no word, one data word, a burst of one to four UTF-8 bytes for a
// \u escape, or the final word with last set and the status. Words leave
// one per cycle while the receiver is ready, from a registered output; the
// queue of QueueDepth bursts absorbs multi-byte bursts so that input keeps
// flowing at one byte per cycle unless escapes arrive faster than the
// output drains. An accepted byte's first word is written into the queue
// and then loaded into the output register.
module json_string_unescape_utf8 #(
  parameter int QueueDepth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  jsu_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output jsu_pkg::out_t out_data_o
);

  jsu_pkg::qstat_t q_stat;
  jsu_pkg::burst_t push_data;
  jsu_pkg::burst_t head;
  logic            push;
  logic            pop;

  jsu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .burst_o    (push_data)
  );

  jsu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (q_stat)
  );

  jsu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- rtl/jsu_front.sv -----
// ----------------------------------------------------------------------------
// JSON string unescaper front end
// Takes one raw byte per cycle while the queue is not full, tracks the escape
// and surrogate state and turns each byte into at most one burst for the queue.
// ----------------------------------------------------------------------------
module jsu_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  jsu_pkg::in_t   in_data_i,
  input  jsu_pkg::qstat_t q_stat_i,
  output logic           push_o,
  output jsu_pkg::burst_t burst_o
);

  jsu_pkg::phase_e phase_q, phase_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [15:0] cu_q, cu_d;
  logic [9:0]  hs_q, hs_d;
  logic        err_q, err_d;

  logic        accept;
  logic [7:0]  b;
  logic        eod;
  logic [4:0]  hexv;
  logic [15:0] cu_n;
  logic        last_digit;
  logic        hi_rng;
  logic        lo_rng;
  logic        is_bs;
  logic        act_plain;
  logic        err_set;
  logic        err_v;
  jsu_pkg::emit_e emit;
  logic [20:0] pair_cp;

  assign in_ready_o = ~q_stat_i.full;
  assign accept     = in_valid_i & in_ready_o;
  assign b          = in_data_i.in_byte;
  assign eod        = in_data_i.end_of_data;
  assign hexv       = jsu_pkg::hex_value(b);
  assign cu_n       = {cu_q[11:0], hexv[3:0]};
  assign last_digit = (cnt_q == 2'd3);
  assign hi_rng     = (cu_n >= jsu_pkg::HighFirst) && (cu_n <= jsu_pkg::HighLast);
  assign lo_rng     = (cu_n >= jsu_pkg::LowFirst) && (cu_n <= jsu_pkg::LowLast);
  assign is_bs      = (b == jsu_pkg::ChBslash);
  assign pair_cp    = jsu_pkg::SuppBase + {1'b0, hs_q, cu_n[9:0]};
  assign err_v      = err_q | err_set;

  // Classify the byte against the current phase.
  always_comb begin
    err_set   = 1'b0;
    act_plain = 1'b0;
    emit      = jsu_pkg::EmNone;
    if (!eod) begin
      unique case (phase_q) inside
        jsu_pkg::PhEsc: begin
          if (!err_q) begin
            case (b) inside
              jsu_pkg::ChQuote, jsu_pkg::ChBslash, jsu_pkg::ChSlash, jsu_pkg::ChLowB,
              jsu_pkg::ChLowF, jsu_pkg::ChLowN, jsu_pkg::ChLowR,
              jsu_pkg::ChLowT: emit = jsu_pkg::EmEsc;
              jsu_pkg::ChLowU: emit = jsu_pkg::EmNone;
              default:         err_set = 1'b1;
            endcase
          end
        end
        jsu_pkg::PhHex, jsu_pkg::PhLowHex: begin
          if (!hexv[4]) begin
            err_set   = 1'b1;
            act_plain = 1'b1;
          end else if (last_digit) begin
            if (phase_q == jsu_pkg::PhHex) begin
              if (lo_rng) begin
                err_set = 1'b1;
              end else if (!hi_rng) begin
                emit = jsu_pkg::EmBmp;
              end
            end else if (lo_rng) begin
              emit = jsu_pkg::EmPair;
            end else begin
              err_set = 1'b1;
            end
          end
        end
        jsu_pkg::PhHigh: begin
          if (!is_bs) begin
            err_set   = 1'b1;
            act_plain = 1'b1;
          end
        end
        jsu_pkg::PhHighBs: begin
          if (b != jsu_pkg::ChLowU) begin
            err_set = 1'b1;
          end
        end
        default: act_plain = 1'b1;
      endcase
      if (act_plain) begin
        if (b == jsu_pkg::ChQuote) begin
          emit = jsu_pkg::EmTerm;
        end else if (is_bs) begin
          emit = jsu_pkg::EmNone;
        end else if (b < jsu_pkg::ChSpace) begin
          err_set = 1'b1;
        end else begin
          emit = jsu_pkg::EmPlain;
        end
      end
    end
  end

  // Next state.
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    cu_d    = cu_q;
    hs_d    = hs_q;
    err_d   = err_v;
    if (eod || emit == jsu_pkg::EmTerm) begin
      phase_d = jsu_pkg::PhPlain;
      cnt_d   = '0;
      cu_d    = '0;
      hs_d    = '0;
      err_d   = 1'b0;
    end else begin
      unique case (phase_q) inside
        jsu_pkg::PhEsc: begin
          phase_d = jsu_pkg::PhPlain;
          if (!err_q && b == jsu_pkg::ChLowU) begin
            phase_d = jsu_pkg::PhHex;
            cnt_d   = '0;
            cu_d    = '0;
          end
        end
        jsu_pkg::PhHex, jsu_pkg::PhLowHex: begin
          if (!hexv[4]) begin
            phase_d = is_bs ? jsu_pkg::PhEsc : jsu_pkg::PhPlain;
          end else if (!last_digit) begin
            cu_d  = cu_n;
            cnt_d = cnt_q + 2'd1;
          end else begin
            cnt_d   = '0;
            cu_d    = '0;
            phase_d = jsu_pkg::PhPlain;
            if (phase_q == jsu_pkg::PhHex) begin
              if (hi_rng) begin
                hs_d    = cu_n[9:0];
                phase_d = jsu_pkg::PhHigh;
              end
            end else begin
              hs_d = '0;
            end
          end
        end
        jsu_pkg::PhHigh: begin
          if (is_bs) begin
            phase_d = jsu_pkg::PhHighBs;
          end else begin
            hs_d    = '0;
            phase_d = jsu_pkg::PhPlain;
          end
        end
        jsu_pkg::PhHighBs: begin
          if (b == jsu_pkg::ChLowU) begin
            phase_d = jsu_pkg::PhLowHex;
            cnt_d   = '0;
            cu_d    = '0;
          end else begin
            hs_d    = '0;
            phase_d = jsu_pkg::PhPlain;
          end
        end
        default: phase_d = is_bs ? jsu_pkg::PhEsc : jsu_pkg::PhPlain;
      endcase
    end
  end

  // Burst for the queue.
  always_comb begin
    burst_o = '0;
    if (eod) begin
      burst_o.term   = 1'b1;
      burst_o.status = jsu_pkg::StatusIncomplete;
    end else begin
      case (emit)
        jsu_pkg::EmTerm: begin
          burst_o.term   = 1'b1;
          burst_o.status = err_v ? jsu_pkg::StatusInvalid : jsu_pkg::StatusOk;
        end
        jsu_pkg::EmPlain: begin
          burst_o.count    = 3'd1;
          burst_o.bytes[0] = b;
        end
        jsu_pkg::EmEsc: begin
          burst_o.count = 3'd1;
          case (b)
            jsu_pkg::ChLowB: burst_o.bytes[0] = jsu_pkg::CtlBs;
            jsu_pkg::ChLowF: burst_o.bytes[0] = jsu_pkg::CtlFf;
            jsu_pkg::ChLowN: burst_o.bytes[0] = jsu_pkg::CtlLf;
            jsu_pkg::ChLowR: burst_o.bytes[0] = jsu_pkg::CtlCr;
            jsu_pkg::ChLowT: burst_o.bytes[0] = jsu_pkg::CtlTab;
            default:         burst_o.bytes[0] = b;
          endcase
        end
        jsu_pkg::EmBmp:  burst_o = jsu_pkg::utf8_encode({5'd0, cu_n});
        jsu_pkg::EmPair: burst_o = jsu_pkg::utf8_encode(pair_cp);
        default:         burst_o = '0;
      endcase
      // After an error no data bytes go out.
      if (err_v && !burst_o.term) begin
        burst_o.count = '0;
      end
    end
    push_o = accept & (burst_o.term | (burst_o.count != 3'd0));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= jsu_pkg::PhPlain;
      cnt_q   <= '0;
      cu_q    <= '0;
      hs_q    <= '0;
      err_q   <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      cu_q    <= cu_d;
      hs_q    <= hs_d;
      err_q   <= err_d;
    end
  end

endmodule

// ----- rtl/jsu_queue.sv -----
// ----------------------------------------------------------------------------
// JSON string unescaper burst queue
// Small first-in first-out buffer of bursts between the front end and the
// output serializer.
// ----------------------------------------------------------------------------
module jsu_queue #(
  parameter int Depth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  jsu_pkg::burst_t push_data_i,
  input  logic            pop_i,
  output jsu_pkg::burst_t head_o,
  output jsu_pkg::qstat_t stat_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);
  localparam logic [PtrW-1:0] PtrOne = PtrW'(1);
  localparam logic [CntW-1:0] CntOne = CntW'(1);

  jsu_pkg::burst_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == FullCnt);
  assign head_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + PtrOne;
    end
    if (pop_i) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + PtrOne;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntOne;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - CntOne;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/jsu_back.sv -----
// ----------------------------------------------------------------------------
// JSON string unescaper output serializer
// Pops bursts from the queue and sends them out one word per cycle, while the
// receiver is ready, through a registered output stage.
// ----------------------------------------------------------------------------
module jsu_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  jsu_pkg::burst_t head_i,
  input  jsu_pkg::qstat_t q_stat_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output jsu_pkg::out_t   out_data_o
);

  logic            out_valid_q, out_valid_d;
  jsu_pkg::out_t   out_q, out_d;
  jsu_pkg::burst_t cur_q, cur_d;
  logic [1:0]      idx_q, idx_d;
  logic            busy_q, busy_d;
  logic            load;

  assign load        = ~out_valid_q | out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    cur_d       = cur_q;
    idx_d       = idx_q;
    busy_d      = busy_q;
    pop_o       = 1'b0;
    if (load) begin
      if (busy_q) begin
        // Continue a multi-byte burst held locally.
        out_valid_d       = 1'b1;
        out_d.out_byte    = cur_q.bytes[idx_q];
        out_d.has_byte    = 1'b1;
        out_d.last        = 1'b0;
        out_d.status      = jsu_pkg::StatusOk;
        idx_d             = idx_q + 2'd1;
        busy_d            = ((3'(idx_q) + 3'd1) != cur_q.count);
      end else if (!q_stat_i.empty) begin
        pop_o       = 1'b1;
        out_valid_d = 1'b1;
        if (head_i.term) begin
          out_d.out_byte = '0;
          out_d.has_byte = 1'b0;
          out_d.last     = 1'b1;
          out_d.status   = head_i.status;
        end else begin
          out_d.out_byte = head_i.bytes[0];
          out_d.has_byte = 1'b1;
          out_d.last     = 1'b0;
          out_d.status   = jsu_pkg::StatusOk;
          if (head_i.count > 3'd1) begin
            cur_d  = head_i;
            idx_d  = 2'd1;
            busy_d = 1'b1;
          end
        end
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      busy_q      <= 1'b0;
      idx_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      busy_q      <= busy_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    cur_q <= cur_d;
  end

endmodule

// ----- verif/json_string_unescape_utf8_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// JSON string unescaper testbench
// Feeds string bodies byte by byte, starting with a short table of directed
// cases and then random strings built mostly from well-formed pieces with
// occasional broken pieces. A behavioral unescaper predicts every output
// word not given by a row; the output stream is checked word by word, in order.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_tb;
  import jsu_pkg::*;

  localparam int NumDirected = 30;
  localparam int RandomItems = 430;

  // One stimulus row. When known is set, want is the single word it yields.
  typedef struct packed {
    logic [7:0] raw;
    logic       eod;
    logic       known;
    out_t       want;
  } row_t;

  localparam out_t NoWord   = '0;
  localparam out_t EndOk    = {8'h00, 1'b0, 1'b1, StatusOk};
  localparam out_t EndBad   = {8'h00, 1'b0, 1'b1, StatusInvalid};
  localparam out_t EndShort = {8'h00, 1'b0, 1'b1, StatusIncomplete};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  json_string_unescape_utf8 dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #4 clk_i = ~clk_i;

  row_t directed_rows [NumDirected] = '{
    {8'h00,    1'b1, 1'b1, EndShort},
    {8'hFF,    1'b0, 1'b1, {8'hFF, 1'b1, 1'b0, StatusOk}},
    {ChBslash, 1'b0, 1'b0, NoWord},
    {ChSlash,  1'b0, 1'b1, {ChSlash, 1'b1, 1'b0, StatusOk}},
    // \u00e9 becomes a two-byte sequence.
    {ChBslash, 1'b0, 1'b0, NoWord},
    {ChLowU,   1'b0, 1'b0, NoWord},
    {8'h30,    1'b0, 1'b0, NoWord},
    {8'h30,    1'b0, 1'b0, NoWord},
    {8'h65,    1'b0, 1'b0, NoWord},
    {8'h39,    1'b0, 1'b0, NoWord},
    // Surrogate pair \uD83D\udE00 becomes a four-byte sequence.
    {ChBslash, 1'b0, 1'b0, NoWord},
    {ChLowU,   1'b0, 1'b0, NoWord},
    {8'h44,    1'b0, 1'b0, NoWord},
    {8'h38,    1'b0, 1'b0, NoWord},
    {8'h33,    1'b0, 1'b0, NoWord},
    {8'h44,    1'b0, 1'b0, NoWord},
    {ChBslash, 1'b0, 1'b0, NoWord},
    {ChLowU,   1'b0, 1'b0, NoWord},
    {8'h64,    1'b0, 1'b0, NoWord},
    {8'h45,    1'b0, 1'b0, NoWord},
    {8'h30,    1'b0, 1'b0, NoWord},
    {8'h30,    1'b0, 1'b0, NoWord},
    {ChQuote,  1'b0, 1'b1, EndOk},
    // A quote in place of a hex digit is a bad digit that also ends the string.
    {ChBslash, 1'b0, 1'b0, NoWord},
    {ChLowU,   1'b0, 1'b0, NoWord},
    {ChQuote,  1'b0, 1'b1, EndBad},
    // Control byte, then a bad escape, then end of data wins over the error.
    {8'h1F,    1'b0, 1'b0, NoWord},
    {ChBslash, 1'b0, 1'b0, NoWord},
    {8'h71,    1'b0, 1'b0, NoWord},
    {8'h00,    1'b1, 1'b1, EndShort}
  };

  row_t rows_q [$];
  out_t due_q [$];
  out_t step_q [$];
  row_t held_row;
  int   rows_total;
  int   words_taken = 0;
  int   words_seen = 0;
  int   errors = 0;

  // Unescaper state.
  phase_e      ph;
  logic [1:0]  ndig;
  logic [15:0] acc;
  logic [9:0]  hi10;
  logic        bad;

  // Sender and receiver pacing.
  int          burst_left = 0;
  int          gap_left = 0;
  int          rdy_mode = 0;
  int          rdy_left = 0;
  int unsigned tick = 0;
  logic        rdy_next;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    errors++;
  endtask

  // ---------------------------------------------------------------------
  // Behavioral unescaper
  // ---------------------------------------------------------------------
  task automatic clear_state();
    ph   = PhPlain;
    ndig = '0;
    acc  = '0;
    hi10 = '0;
    bad  = 1'b0;
  endtask

  task automatic put_data(input logic [7:0] c);
    if (!bad) begin
      step_q.push_back({c, 1'b1, 1'b0, StatusOk});
    end
  endtask

  task automatic put_code_point(input logic [20:0] cp);
    if (cp < 21'h80) begin
      put_data(cp[7:0]);
    end else if (cp < 21'h800) begin
      put_data(Lead2 | {3'b000, cp[10:6]});
      put_data(ContMark | {2'b00, cp[5:0]});
    end else if (cp < 21'h10000) begin
      put_data(Lead3 | {4'h0, cp[15:12]});
      put_data(ContMark | {2'b00, cp[11:6]});
      put_data(ContMark | {2'b00, cp[5:0]});
    end else begin
      put_data(Lead4 | {5'h00, cp[20:18]});
      put_data(ContMark | {2'b00, cp[17:12]});
      put_data(ContMark | {2'b00, cp[11:6]});
      put_data(ContMark | {2'b00, cp[5:0]});
    end
  endtask

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 48;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 87;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 55;
    return -1;
  endfunction

  task automatic plain_in(input logic [7:0] c);
    ph = PhPlain;
    if (c == ChQuote) begin
      step_q.push_back(bad ? EndBad : EndOk);
      clear_state();
    end else if (c == ChBslash) begin
      ph = PhEsc;
    end else if (c < ChSpace) begin
      bad = 1'b1;
    end else begin
      put_data(c);
    end
  endtask

  task automatic escape_in(input logic [7:0] c);
    ph = PhPlain;
    if (!bad) begin
      case (c)
        ChQuote:  put_data(ChQuote);
        ChBslash: put_data(ChBslash);
        ChSlash:  put_data(ChSlash);
        ChLowB:   put_data(CtlBs);
        ChLowF:   put_data(CtlFf);
        ChLowN:   put_data(CtlLf);
        ChLowR:   put_data(CtlCr);
        ChLowT:   put_data(CtlTab);
        ChLowU: begin
          ph   = PhHex;
          ndig = '0;
          acc  = '0;
        end
        default:  bad = 1'b1;
      endcase
    end
  endtask

  task automatic hex_in(input logic [7:0] c, input logic low);
    int d;
    logic [15:0] cu;
    d = hex_digit(c);
    if (d < 0) begin
      // The offending byte is reinterpreted as plain text.
      bad = 1'b1;
      plain_in(c);
      return;
    end
    cu = {acc[11:0], 4'(d)};
    if (ndig < 2'd3) begin
      acc  = cu;
      ndig = ndig + 2'd1;
      return;
    end
    ndig = '0;
    acc  = '0;
    ph   = PhPlain;
    if (!low) begin
      if (cu >= HighFirst && cu <= HighLast) begin
        hi10 = cu[9:0];
        ph   = PhHigh;
      end else if (cu >= LowFirst && cu <= LowLast) begin
        bad = 1'b1;
      end else begin
        put_code_point({5'h00, cu});
      end
    end else begin
      if (cu >= LowFirst && cu <= LowLast) begin
        put_code_point(21'h10000 + {1'b0, hi10, cu[9:0]});
      end else begin
        bad = 1'b1;
      end
      hi10 = '0;
    end
  endtask

  // Leaves in step_q the words that one input word produces.
  task automatic unescape_byte(input in_t w);
    step_q.delete();
    if (w.end_of_data) begin
      step_q.push_back(EndShort);
      clear_state();
      return;
    end
    case (ph)
      PhEsc:    escape_in(w.in_byte);
      PhHex:    hex_in(w.in_byte, 1'b0);
      PhHigh: begin
        if (w.in_byte == ChBslash) begin
          ph = PhHighBs;
        end else begin
          bad  = 1'b1;
          hi10 = '0;
          plain_in(w.in_byte);
        end
      end
      PhHighBs: begin
        if (w.in_byte == ChLowU) begin
          ph   = PhLowHex;
          ndig = '0;
          acc  = '0;
        end else begin
          bad  = 1'b1;
          hi10 = '0;
          ph   = PhPlain;
        end
      end
      PhLowHex: hex_in(w.in_byte, 1'b1);
      default:  plain_in(w.in_byte);
    endcase
  endtask

  task automatic take_row(input row_t r);
    unescape_byte({r.raw, r.eod});
    if (r.known) begin
      due_q.push_back(r.want);
    end else begin
      foreach (step_q[i]) due_q.push_back(step_q[i]);
    end
    words_taken++;
  endtask

  task automatic check_word(input out_t got);
    out_t w;
    if (due_q.size() == 0) begin
      report_mismatch($sformatf("word %0d: unexpected %h/%b/%b/%0d", words_seen,
                                got.out_byte, got.has_byte, got.last, got.status));
    end else begin
      w = due_q.pop_front();
      if (got.out_byte !== w.out_byte || got.has_byte !== w.has_byte ||
          got.last !== w.last || got.status !== w.status) begin
        report_mismatch($sformatf("word %0d: got %h/%b/%b/%0d want %h/%b/%b/%0d",
                                  words_seen, got.out_byte, got.has_byte, got.last,
                                  got.status, w.out_byte, w.has_byte, w.last, w.status));
      end
    end
    words_seen++;
  endtask

  // ---------------------------------------------------------------------
  // Random string builder
  // ---------------------------------------------------------------------
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + {4'h0, n};
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + {4'h0, n} - 8'd10;
  endfunction

  function automatic logic [7:0] escape_char(input int k);
    case (k)
      0:       return ChQuote;
      1:       return ChBslash;
      2:       return ChSlash;
      3:       return ChLowB;
      4:       return ChLowF;
      5:       return ChLowN;
      6:       return ChLowR;
      default: return ChLowT;
    endcase
  endfunction

  function automatic logic is_escape(input logic [7:0] c);
    for (int k = 0; k < 8; k++) begin
      if (c == escape_char(k)) return 1'b1;
    end
    return c == ChLowU;
  endfunction

  task automatic push_raw(input logic [7:0] c);
    rows_q.push_back({c, 1'b0, 1'b0, NoWord});
  endtask

  task automatic push_u(input logic [15:0] cu);
    push_raw(ChBslash);
    push_raw(ChLowU);
    for (int i = 3; i >= 0; i--) push_raw(hex_char(cu[i*4 +: 4]));
  endtask

  task automatic push_clean();
    int k;
    logic [7:0] c;
    logic [15:0] cu;
    k = $urandom_range(0, 99);
    if (k < 45) begin
      do c = 8'($urandom_range(32, 255)); while (c == ChQuote || c == ChBslash);
      push_raw(c);
    end else if (k < 65) begin
      push_raw(ChBslash);
      push_raw(escape_char($urandom_range(0, 7)));
    end else if (k < 85) begin
      do begin
        case ($urandom_range(0, 3))
          0: cu = 16'($urandom_range(0, 16'h7F));
          1: cu = 16'($urandom_range(16'h80, 16'h7FF));
          2: cu = 16'($urandom);
          default: begin
            case ($urandom_range(0, 7))
              0: cu = 16'h0000;
              1: cu = 16'h007F;
              2: cu = 16'h0080;
              3: cu = 16'h07FF;
              4: cu = 16'h0800;
              5: cu = 16'hD7FF;
              6: cu = 16'hE000;
              default: cu = 16'hFFFF;
            endcase
          end
        endcase
      end while (cu >= HighFirst && cu <= LowLast);
      push_u(cu);
    end else begin
      push_u(HighFirst | 16'($urandom_range(0, 1023)));
      push_u(LowFirst | 16'($urandom_range(0, 1023)));
    end
  endtask

  // Broken pieces: all but a stray random byte set the sticky error.
  task automatic push_noise();
    logic [7:0] c;
    logic [15:0] cu;
    case ($urandom_range(0, 7))
      0: push_raw(8'($urandom_range(0, 31)));
      1: begin
        do c = 8'($urandom); while (is_escape(c));
        push_raw(ChBslash);
        push_raw(c);
      end
      2: begin
        push_raw(ChBslash);
        push_raw(ChLowU);
        repeat ($urandom_range(0, 3)) push_raw(hex_char(4'($urandom)));
        do c = 8'($urandom); while (hex_digit(c) >= 0);
        push_raw(c);
      end
      3: push_u(LowFirst | 16'($urandom_range(0, 1023)));
      4: begin
        push_u(HighFirst | 16'($urandom_range(0, 1023)));
        do c = 8'($urandom); while (c == ChBslash);
        push_raw(c);
      end
      5: begin
        push_u(HighFirst | 16'($urandom_range(0, 1023)));
        do c = 8'($urandom); while (c == ChLowU);
        push_raw(ChBslash);
        push_raw(c);
      end
      6: begin
        push_u(HighFirst | 16'($urandom_range(0, 1023)));
        do cu = 16'($urandom); while (cu >= LowFirst && cu <= LowLast);
        push_u(cu);
      end
      default: push_raw(8'($urandom));
    endcase
  endtask

  task automatic push_string();
    int len;
    int dirty_at;
    len = $urandom_range(0, 10);
    dirty_at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, len) : -1;
    for (int i = 0; i < len; i++) begin
      if (i == dirty_at) push_noise();
      push_clean();
    end
    if (dirty_at == len) push_noise();
    if ($urandom_range(0, 9) == 0) begin
      // Input runs out, sometimes in the middle of an escape.
      if ($urandom_range(0, 1)) push_raw(ChBslash);
      rows_q.push_back({8'($urandom), 1'b1, 1'b0, NoWord});
    end else begin
      push_raw(ChQuote);
    end
  endtask

  // ---------------------------------------------------------------------
  // Driver and monitor
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      // Predict first so that a word of the same edge finds its expectation.
      if (in_valid_i && in_ready_o) take_row(held_row);
      if (out_valid_o && out_ready_i) check_word(out_data_o);

      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0 || rows_q.size() == 0) begin
          if (gap_left != 0) gap_left--;
          in_valid_i <= 1'b0;
        end else begin
          held_row = rows_q.pop_front();
          in_data_i  <= {held_row.raw, held_row.eod};
          in_valid_i <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end
      end

      if (rdy_left == 0) begin
        rdy_mode = $urandom_range(0, 3);
        rdy_left = $urandom_range(16, 120);
      end else begin
        rdy_left--;
      end
      case (rdy_mode)
        0:       rdy_next = 1'b1;
        1:       rdy_next = ($urandom_range(0, 3) != 0);
        2:       rdy_next = ($urandom_range(0, 2) == 0);
        default: rdy_next = (tick % 5 == 0);
      endcase
      out_ready_i <= rdy_next;
      tick++;
    end
  end

  initial begin
    clear_state();
    for (int i = 0; i < NumDirected; i++) rows_q.push_back(directed_rows[i]);
    while (rows_q.size() < NumDirected + RandomItems) push_string();
    rows_total = rows_q.size();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (words_taken != rows_total) @(posedge clk_i);
    for (int i = 0; i < 5000 && due_q.size() != 0; i++) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (due_q.size() != 0) begin
      report_mismatch($sformatf("%0d expected words never arrived", due_q.size()));
    end
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
